// ===== rtl/core/rdf_pkg.sv =====
// rdf_pkg: shared types and constants for the recent identifier duplicate filter.
// No dependencies; used by rdf_ring, rdf_seq and recent_id_duplicate_filter.
package rdf_pkg;

    localparam int ID_W = 64;

    typedef logic [ID_W-1:0] id_t;

endpackage

// ===== rtl/core/rdf_ring.sv =====
// rdf_ring: identifier ring storage, one write port and one registered read port.
// Depends on rdf_pkg (id_t).
module rdf_ring #(
    parameter int WINDOW_DEPTH = 512,
    parameter int SLOT_W       = 9
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [SLOT_W-1:0] wr_addr,
    input  rdf_pkg::id_t      wr_data,
    input  logic              rd_en,
    input  logic [SLOT_W-1:0] rd_addr,
    output rdf_pkg::id_t      rd_data
);

    rdf_pkg::id_t mem [WINDOW_DEPTH];
    rdf_pkg::id_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/rdf_seq.sv =====
// rdf_seq: lookup sequencer with one shared 64-bit comparator, ring bookkeeping.
// Depends on rdf_pkg (id_t); drives the ports of rdf_ring.
module rdf_seq #(
    parameter int WINDOW_DEPTH = 512,
    parameter int SLOT_W       = 9,
    parameter int OCC_W        = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rdf_pkg::id_t      message_id,
    input  logic              enable,
    output logic              res_valid,
    input  logic              res_take,
    output logic              res_seen,
    output logic              wr_en,
    output logic [SLOT_W-1:0] wr_addr,
    output rdf_pkg::id_t      wr_data,
    output logic              rd_en,
    output logic [SLOT_W-1:0] rd_addr,
    input  rdf_pkg::id_t      rd_data
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_RECORD = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    localparam logic [OCC_W-1:0]  OCC_FULL = OCC_W'(WINDOW_DEPTH);
    localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(WINDOW_DEPTH - 1);

    logic [1:0]        state_reg, state_next;
    rdf_pkg::id_t      id_reg, id_next;
    logic [OCC_W-1:0]  idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic              seen_reg, seen_next;
    logic [OCC_W-1:0]  occ_reg, occ_next;
    logic [SLOT_W-1:0] oldest_reg, oldest_next;
    logic              full;
    logic              hit;

    assign full = (occ_reg == OCC_FULL);
    assign hit  = pend_reg && (rd_data == id_reg);

    always_comb
    begin
        state_next  = state_reg;
        id_next     = id_reg;
        idx_next    = idx_reg;
        pend_next   = 1'b0;
        seen_next   = seen_reg;
        occ_next    = occ_reg;
        oldest_next = oldest_reg;
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    id_next   = message_id;
                    idx_next  = '0;
                    seen_next = 1'b0;
                    if (enable && (message_id != '0))
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_RESULT;
                    end
                end
            end
            S_SCAN:
            begin
                rd_en     = (idx_reg < occ_reg);
                pend_next = rd_en;
                if (rd_en)
                begin
                    idx_next = idx_reg + OCC_W'(1);
                end
                if (hit)
                begin
                    seen_next  = 1'b1;
                    state_next = S_RESULT;
                end
                else if (!rd_en)
                begin
                    state_next = S_RECORD;
                end
            end
            S_RECORD:
            begin
                wr_en = 1'b1;
                if (full)
                begin
                    oldest_next = (oldest_reg == SLOT_MAX) ? '0 : oldest_reg + SLOT_W'(1);
                end
                else
                begin
                    occ_next = occ_reg + OCC_W'(1);
                end
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // while the ring is filling, oldest stays at slot zero
    assign wr_addr  = full ? oldest_reg : occ_reg[SLOT_W-1:0];
    assign wr_data  = id_reg;
    assign rd_addr  = idx_reg[SLOT_W-1:0];
    assign res_seen = seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pend_reg   <= 1'b0;
            occ_reg    <= '0;
            oldest_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            pend_reg   <= pend_next;
            occ_reg    <= occ_next;
            oldest_reg <= oldest_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        idx_reg  <= idx_next;
        seen_reg <= seen_next;
    end

endmodule

// ===== rtl/core/recent_id_duplicate_filter.sv =====
// recent_id_duplicate_filter: top level, enable register, sequencer, ring, output stage.
// Depends on rdf_pkg, rdf_ring and rdf_seq.
//
// Each request carries a 64-bit message_id and yields one seen flag. The ring of
// WINDOW_DEPTH identifiers is searched one entry per cycle through its single read
// port, up to the current occupancy (at most WINDOW_DEPTH entries), and the search
// stops early on a match; a zero identifier or a disabled filter skips the search
// and the record step. One request is in flight at a time; in_ready is high while
// the sequencer is idle, which it becomes at the same edge as the previous result
// enters the output register, and a result waiting there does not block acceptance.
// Write filter_enable only while no request is in flight.
module recent_id_duplicate_filter #(
    parameter int WINDOW_DEPTH = 512
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         filter_enable,
    input  logic         in_valid,
    output logic         in_ready,
    input  rdf_pkg::id_t message_id,
    output logic         out_valid,
    input  logic         out_ready,
    output logic         seen
);

    localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int OCC_W  = $clog2(WINDOW_DEPTH + 1);

    logic              enable_reg;
    logic              out_valid_reg;
    logic              seen_reg;
    logic              res_valid;
    logic              res_take;
    logic              res_seen;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    rdf_pkg::id_t      wr_data;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    rdf_pkg::id_t      rd_data;

    assign cfg_ready = 1'b1;
    assign res_take  = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                enable_reg <= filter_enable;
            end
            if (res_take)
            begin
                out_valid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take && res_valid)
        begin
            seen_reg <= res_seen;
        end
    end

    rdf_seq #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SLOT_W       (SLOT_W),
        .OCC_W        (OCC_W)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .message_id (message_id),
        .enable     (enable_reg),
        .res_valid  (res_valid),
        .res_take   (res_take),
        .res_seen   (res_seen),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    rdf_ring #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SLOT_W       (SLOT_W)
    ) u_ring (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_valid = out_valid_reg;
    assign seen      = seen_reg;

endmodule

// ===== bench/recent_id_duplicate_filter_test.sv =====
// recent_id_duplicate_filter_test: self-checking bench for the recent identifier duplicate filter.
// Drives directed and random requests under random backpressure and checks every seen flag
// against a FIFO-window predictor kept here. Depends on rdf_pkg and recent_id_duplicate_filter.
module recent_id_duplicate_filter_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 512;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int HOLD_CYCLES = 700;

    logic         clk;
    logic         rst_n;
    logic         cfg_valid;
    logic         cfg_ready;
    logic         filter_enable;
    logic         in_valid;
    logic         in_ready;
    rdf_pkg::id_t message_id;
    logic         out_valid;
    logic         out_ready;
    logic         seen;

    typedef struct {
        rdf_pkg::id_t id;
        bit           seen;
    } seen_entry_t;

    class seen_tracker;
        rdf_pkg::id_t ring[DEPTH];
        int unsigned  fill;
        int unsigned  oldest;
        bit           enabled;
        rdf_pkg::id_t evicted[$];
        seen_entry_t  pending[$];
        int           errors;
        int           results;

        function new();
            fill = 0;
            oldest = 0;
            enabled = 1'b0;
            errors = 0;
            results = 0;
        endfunction

        function rdf_pkg::id_t slot_id(int unsigned k);
            return ring[(oldest + k) % DEPTH];
        endfunction

        function bit holds(rdf_pkg::id_t id);
            for (int unsigned k = 0; k < fill; k++)
                if (slot_id(k) == id)
                    return 1'b1;
            return 1'b0;
        endfunction

        function void store(rdf_pkg::id_t id);
            if (fill < DEPTH)
            begin
                ring[(oldest + fill) % DEPTH] = id;
                fill++;
            end
            else
            begin
                evicted.insert(evicted.size(), ring[oldest]);
                if (evicted.size() > 32)
                    evicted.delete(0);
                ring[oldest] = id;
                oldest = (oldest + 1) % DEPTH;
            end
        endfunction

        function void note_id(rdf_pkg::id_t id);
            seen_entry_t e;
            e.id = id;
            e.seen = 1'b0;
            if (id != '0 && enabled)
            begin
                e.seen = holds(id);
                if (!e.seen)
                    store(id);
            end
            pending.insert(pending.size(), e);
        endfunction

        function void check_seen(logic got);
            seen_entry_t e;
            results++;
            if (pending.size() == 0)
            begin
                $display("%0t: unrequested result, expected none actual seen=%b", $time, got);
                errors++;
            end
            else
            begin
                e = pending[0];
                pending.delete(0);
                if (got !== e.seen)
                begin
                    $display("%0t: seen for id %h, expected %0b actual %b",
                             $time, e.id, e.seen, got);
                    errors++;
                end
            end
        endfunction
    endclass

    seen_tracker board;

    rdf_pkg::id_t directed_ids[11] = '{
        64'h1, 64'h1, '1, '1, '0, 64'h8000_0000_0000_0000, 64'h1234,
        64'h1, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFE, 64'h2
    };

    recent_id_duplicate_filter #(.WINDOW_DEPTH(DEPTH)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .filter_enable(filter_enable),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .message_id   (message_id),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .seen         (seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic rdf_pkg::id_t pick_id();
        int unsigned r;
        int unsigned span;
        r = $urandom_range(99);
        if (r < 55)
        begin
            if (r < 4)
                return rdf_pkg::id_t'($urandom_range(8, 1));
            return {$urandom, $urandom};
        end
        if (board.fill != 0)
        begin
            if (r < 75)
                return board.slot_id($urandom_range(board.fill - 1));
            if (r < 83)
            begin
                span = (board.fill < 4) ? board.fill - 1 : 3;
                return board.slot_id($urandom_range(span));
            end
            if (r >= 97)
                return board.slot_id(board.fill - 1);
        end
        if (r < 90 && board.evicted.size() != 0)
            return board.evicted[$urandom_range(board.evicted.size() - 1)];
        if (r < 93)
            return '0;
        if (r < 95)
            return rdf_pkg::id_t'(1) << $urandom_range(63);
        if (r < 97)
            return ~(rdf_pkg::id_t'(1) << $urandom_range(63));
        return {$urandom, $urandom};
    endfunction

    task automatic send_id(input rdf_pkg::id_t id);
        in_valid <= 1'b1;
        message_id <= id;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_id(id);
    endtask

    task automatic send_random(input int count);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(12, 1);
            for (int i = 0; i < burst && sent < count; i++)
            begin
                send_id(pick_id());
                sent++;
            end
            if ($urandom_range(3) == 0)
                gap = $urandom_range(30, 1);
            else
                gap = $urandom_range(1) ? $urandom_range(4, 1) : 0;
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_enable(input logic value);
        cfg_valid <= 1'b1;
        filter_enable <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.enabled = value;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_seen(seen);
    end

    initial
    begin : receiver
        int hold_at;
        int span;
        int mode;
        out_ready <= 1'b0;
        hold_at = 40;
        wait (rst_n === 1'b1);
        forever
        begin
            if (board.results >= hold_at)
            begin
                // hold off long enough for the filter to back up its input
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_at += HOLD_CYCLES;
            end
            else
            begin
                span = $urandom_range(40, 1);
                mode = $urandom_range(3);
                repeat (span)
                begin
                    case (mode)
                        0: out_ready <= 1'b1;
                        1: out_ready <= ($urandom_range(1) == 1);
                        2: out_ready <= ($urandom_range(3) == 0);
                        default: out_ready <= ($urandom_range(3) != 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin : stimulus
        board = new();
        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        filter_enable <= 1'b0;
        in_valid <= 1'b0;
        message_id <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // disabled out of reset: nothing is recorded
        send_id(64'h1234);
        send_id('0);
        send_id(64'h1234);
        in_valid <= 1'b0;
        drain();

        write_enable(1'b1);
        foreach (directed_ids[i])
            send_id(directed_ids[i]);
        in_valid <= 1'b0;
        drain();

        // disable keeps stored entries; re-enable uses them again
        write_enable(1'b0);
        send_id(64'h1);
        send_id(64'hAAAA_AAAA_5555_5555);
        in_valid <= 1'b0;
        drain();
        write_enable(1'b1);
        send_id(64'h1);
        send_id(64'hAAAA_AAAA_5555_5555);
        send_id(64'hAAAA_AAAA_5555_5555);
        in_valid <= 1'b0;
        drain();

        send_random(500);
        drain();
        write_enable(1'b0);
        send_random(60);
        drain();
        write_enable(1'b1);
        send_random(580);
        drain();
        repeat (DEPTH + 8) @(posedge clk);

        if (board.errors == 0 && board.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
